// ===== src/wcfrh_pkg.sv =====
// ----------------------------------------------------------------------------
// wcfrh_pkg
// Shared types, constants and the vendor prefix table for the capture filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wcfrh_pkg;

    // Field widths of the frame descriptor and the record header.
    localparam int unsigned TS_W     = 32;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned FC_W     = 16;
    localparam int unsigned PREFIX_W = 24;
    localparam int unsigned SEC_W    = 13;
    localparam int unsigned USEC_W   = 20;

    // Frame size limits.
    localparam int unsigned MAX_FRAME_BYTES = 2346;
    localparam int unsigned HEADER_BYTES    = 24;
    localparam int unsigned CTRL_MIN_BYTES  = 16;
    localparam int unsigned ADDR4_BYTES     = 6;

    // Frame control layout.
    localparam int unsigned FC_TYPE_LSB    = 2;
    localparam int unsigned FC_SUBTYPE_LSB = 4;
    localparam int unsigned FC_TO_DS_BIT   = 8;
    localparam int unsigned FC_FROM_DS_BIT = 9;
    localparam logic [3:0]  CTRL_SUB_LO    = 4'd8;
    localparam logic [3:0]  CTRL_SUB_HI    = 4'd11;

    typedef enum logic [1:0] {
        FT_MGMT = 2'd0,
        FT_CTRL = 2'd1,
        FT_DATA = 2'd2,
        FT_RSVD = 2'd3
    } t_frame_type;

    typedef enum logic [1:0] {
        OUTCOME_WRITTEN = 2'd0,
        OUTCOME_SKIPPED = 2'd1,
        OUTCOME_ERROR   = 2'd2
    } t_outcome;

    // Timestamp split: q = (ts * RECIP_MULT) >> RECIP_SHIFT is the true quotient
    // or one less, so a single compare and subtract finishes the job.
    localparam int unsigned     USEC_PER_SEC    = 1000000;
    localparam int unsigned     RECIP_SHIFT     = 50;
    localparam int unsigned     RECIP_W         = 31;
    localparam int unsigned     PROD_W          = TS_W + RECIP_W;
    localparam longint unsigned RECIP_MULT_FULL = (64'd1 << RECIP_SHIFT) / USEC_PER_SEC;
    localparam logic [RECIP_W-1:0] RECIP_MULT   = RECIP_MULT_FULL[RECIP_W-1:0];

    // Result of source selection and table lookup.
    typedef struct packed {
        logic has_source;
        logic listed;
    } t_src_match;

    localparam int unsigned VENDOR_COUNT = 109;

    localparam logic [PREFIX_W-1:0] VENDOR_PREFIXES [VENDOR_COUNT] = '{
        24'h0009bf, 24'h001656, 24'h0017ab, 24'h00191d, 24'h0019fd, 24'h001ae9,
        24'h001b7a, 24'h001bea, 24'h001cbe, 24'h001dbc, 24'h001e35, 24'h001ea9,
        24'h001f32, 24'h001fc5, 24'h002147, 24'h0021bd, 24'h00224c, 24'h0022aa,
        24'h0022d7, 24'h002331, 24'h0023cc, 24'h00241e, 24'h002444, 24'h0024f3,
        24'h0025a0, 24'h002659, 24'h002709, 24'h0403d6, 24'h182a7b, 24'h1c4586,
        24'h200bcf, 24'h201c3a, 24'h28cf51, 24'h2c10c1, 24'h3089ec, 24'h342fbd,
        24'h34af2c, 24'h38c6ce, 24'h3ca9ab, 24'h4044f7, 24'h40d28a, 24'h40f407,
        24'h483177, 24'h48a5e7, 24'h48f1eb, 24'h4c306a, 24'h50236d, 24'h582f40,
        24'h58b03e, 24'h58bda3, 24'h5c0ce6, 24'h5c521e, 24'h601ac7, 24'h606bff,
        24'h64b5c6, 24'h702c09, 24'h7048f7, 24'h70f088, 24'h748469, 24'h74f9ca,
        24'h7820a5, 24'h78818c, 24'h78a2a0, 24'h7cbb8a, 24'h80d2e5, 24'h84c065,
        24'h8c56c5, 24'h8ccde8, 24'h904528, 24'h9458cb, 24'h948e6d, 24'h98415c,
        24'h98b6e9, 24'h98e255, 24'h98e8fa, 24'h9ce635, 24'ha438cc, 24'ha45c27,
        24'ha4c0e1, 24'ha4c1e8, 24'hacfae4, 24'hb86870, 24'hb87826, 24'hb88aec,
        24'hb8ae6e, 24'hbc744b, 24'hbc89a6, 24'hbc9ebb, 24'hbcce25, 24'hc0a4cf,
        24'hc84805, 24'hc89143, 24'hcc5b31, 24'hcc9e00, 24'hccfb65, 24'hd05509,
        24'hd4f057, 24'hd86b83, 24'hd86bf7, 24'hdc68eb, 24'hdccd18, 24'he00c7f,
        24'he0e751, 24'he0efbf, 24'he0f6b5, 24'he84ece, 24'he8a0cd, 24'he8da20,
        24'hecc40d
    };

    // Parallel compare of one prefix against every table entry.
    function automatic logic prefix_listed(input logic [PREFIX_W-1:0] prefix);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < VENDOR_COUNT; i++) begin
            hit = hit | (VENDOR_PREFIXES[i] == prefix);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== src/wcfrh_frame_if.sv =====
// ----------------------------------------------------------------------------
// wcfrh_frame_if
// Request channel carrying one captured frame descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

interface wcfrh_frame_if;
    import wcfrh_pkg::*;

    logic                valid;
    logic                ready;
    logic [TS_W-1:0]     timestamp_us;
    logic [LEN_W-1:0]    frame_length;
    logic [FC_W-1:0]     frame_control;
    logic [PREFIX_W-1:0] addr_at_10_prefix;
    logic [PREFIX_W-1:0] addr_at_16_prefix;
    logic [PREFIX_W-1:0] addr_at_24_prefix;
    logic                apply_filter;

    modport source (
        output valid, timestamp_us, frame_length, frame_control,
               addr_at_10_prefix, addr_at_16_prefix, addr_at_24_prefix, apply_filter,
        input  ready
    );

    modport sink (
        input  valid, timestamp_us, frame_length, frame_control,
               addr_at_10_prefix, addr_at_16_prefix, addr_at_24_prefix, apply_filter,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/wcfrh_rec_if.sv =====
// ----------------------------------------------------------------------------
// wcfrh_rec_if
// Request channel carrying one record header result.
// ----------------------------------------------------------------------------
`default_nettype none

interface wcfrh_rec_if;
    import wcfrh_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        outcome;
    logic [SEC_W-1:0]  seconds;
    logic [USEC_W-1:0] microseconds;
    logic [LEN_W-1:0]  captured_length;

    modport source (
        output valid, outcome, seconds, microseconds, captured_length,
        input  ready
    );

    modport sink (
        input  valid, outcome, seconds, microseconds, captured_length,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/wifi_capture_filter_record_header_top.sv =====
// ----------------------------------------------------------------------------
// wifi_capture_filter_record_header_top
// Source prefix filter and capture record header builder for 802.11 frames.
// ----------------------------------------------------------------------------
// Usage: i_frame carries one frame descriptor per request (timestamp, length,
// frame control word, three candidate address prefixes and the filter enable).
// o_rec returns exactly one record header request for each frame, in order:
// the outcome (written, skipped or error) and, for written frames, seconds,
// microseconds and the clamped captured length; other outcomes carry zeros.
// The result passes through the input register, loaded at the accepting edge
// on i_frame, then the decision stage, the reciprocal multiply stage and the
// output register, which drives o_rec as valid. One frame is accepted every
// cycle while the receiver does not stall; the only recurrence is the last
// written timestamp, which is compared, bumped and stored within the single
// decision stage. When the receiver stalls, every stage holds its request and
// empty stages keep filling, so i_frame.ready drops only once all four stages
// are full.
// A synchronous active-low reset empties the pipeline and clears the last
// written timestamp to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_capture_filter_record_header_top #(
    parameter int unsigned P_MAX_FRAME_BYTES = wcfrh_pkg::MAX_FRAME_BYTES
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wcfrh_frame_if.sink  i_frame,
    wcfrh_rec_if.source  o_rec
);
    import wcfrh_pkg::*;

    // Stage 0: input register, so the decision logic starts from flops.
    logic                r_s0_valid;
    logic [TS_W-1:0]     r_s0_ts;
    logic [LEN_W-1:0]    r_s0_len;
    logic [FC_W-1:0]     r_s0_fc;
    logic [PREFIX_W-1:0] r_s0_a10;
    logic [PREFIX_W-1:0] r_s0_a16;
    logic [PREFIX_W-1:0] r_s0_a24;
    logic                r_s0_filt;

    // Stage 1: decision results and the adjusted timestamp.
    logic                r_s1_valid;
    t_outcome            r_s1_outcome;
    logic [TS_W-1:0]     r_s1_ts;
    logic [LEN_W-1:0]    r_s1_len;

    // Timestamp of the most recent written frame.
    logic [TS_W-1:0]     r_last_ts;

    t_src_match          w_match;
    logic                w_s1_ready;
    logic                w_s2_ready;
    logic                w_s0_move;
    logic                w_zero_len;
    logic                w_skip;
    logic                w_write;
    logic [TS_W-1:0]     w_ts_adj;
    logic [LEN_W-1:0]    w_len_clamp;
    t_outcome            n_s1_outcome;
    logic [TS_W-1:0]     n_s1_ts;
    logic [LEN_W-1:0]    n_s1_len;

    assign w_s1_ready    = !r_s1_valid || w_s2_ready;
    assign i_frame.ready = !r_s0_valid || w_s1_ready;
    assign w_s0_move     = r_s0_valid && w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_s0_valid <= i_frame.valid;
        end
        if (i_frame.ready && i_frame.valid) begin
            r_s0_ts   <= i_frame.timestamp_us;
            r_s0_len  <= i_frame.frame_length;
            r_s0_fc   <= i_frame.frame_control;
            r_s0_a10  <= i_frame.addr_at_10_prefix;
            r_s0_a16  <= i_frame.addr_at_16_prefix;
            r_s0_a24  <= i_frame.addr_at_24_prefix;
            r_s0_filt <= i_frame.apply_filter;
        end
    end

    wcfrh_src_filter u_src_filter (
        .i_frame_length      (r_s0_len),
        .i_frame_control     (r_s0_fc),
        .i_addr_at_10_prefix (r_s0_a10),
        .i_addr_at_16_prefix (r_s0_a16),
        .i_addr_at_24_prefix (r_s0_a24),
        .o_match             (w_match)
    );

    // A zero length is an error regardless of the filter setting. With the
    // filter on, a frame needs a usable source whose prefix is in the table.
    assign w_zero_len = r_s0_len == '0;
    assign w_skip     = !w_zero_len && r_s0_filt && !(w_match.has_source && w_match.listed);
    assign w_write    = !w_zero_len && !w_skip;

    // Written timestamps never go backwards; an equal one is kept.
    assign w_ts_adj    = (r_s0_ts < r_last_ts) ? (r_last_ts + TS_W'(1)) : r_s0_ts;
    assign w_len_clamp = (r_s0_len > LEN_W'(P_MAX_FRAME_BYTES)) ?
                         LEN_W'(P_MAX_FRAME_BYTES) : r_s0_len;

    always_comb begin
        n_s1_outcome = OUTCOME_WRITTEN;
        n_s1_ts      = '0;
        n_s1_len     = '0;
        if (w_zero_len) begin
            n_s1_outcome = OUTCOME_ERROR;
        end else if (w_skip) begin
            n_s1_outcome = OUTCOME_SKIPPED;
        end else begin
            n_s1_ts  = w_ts_adj;
            n_s1_len = w_len_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_last_ts  <= '0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= r_s0_valid;
            end
            if (w_s0_move && w_write) begin
                r_last_ts <= w_ts_adj;
            end
        end
        if (w_s0_move) begin
            r_s1_outcome <= n_s1_outcome;
            r_s1_ts      <= n_s1_ts;
            r_s1_len     <= n_s1_len;
        end
    end

    // Seconds and microseconds split, ending in the output register.
    wcfrh_usec_split u_usec_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .o_ready   (w_s2_ready),
        .i_ts      (r_s1_ts),
        .i_outcome (r_s1_outcome),
        .i_len     (r_s1_len),
        .o_rec     (o_rec)
    );

endmodule

`default_nettype wire

// ===== src/wcfrh_src_filter.sv =====
// ----------------------------------------------------------------------------
// wcfrh_src_filter
// Picks the source address prefix from the frame control word and length,
// and looks it up in the vendor prefix table.
// ----------------------------------------------------------------------------
`default_nettype none

module wcfrh_src_filter (
    input  wire logic [wcfrh_pkg::LEN_W-1:0]    i_frame_length,
    input  wire logic [wcfrh_pkg::FC_W-1:0]     i_frame_control,
    input  wire logic [wcfrh_pkg::PREFIX_W-1:0] i_addr_at_10_prefix,
    input  wire logic [wcfrh_pkg::PREFIX_W-1:0] i_addr_at_16_prefix,
    input  wire logic [wcfrh_pkg::PREFIX_W-1:0] i_addr_at_24_prefix,
    output wcfrh_pkg::t_src_match               o_match
);
    import wcfrh_pkg::*;

    t_frame_type         w_type;
    logic [3:0]          w_subtype;
    logic                w_to_ds;
    logic                w_from_ds;
    logic                w_has_source;
    logic [PREFIX_W-1:0] w_prefix;

    assign w_type    = t_frame_type'(i_frame_control[FC_TYPE_LSB +: 2]);
    assign w_subtype = i_frame_control[FC_SUBTYPE_LSB +: 4];
    assign w_to_ds   = i_frame_control[FC_TO_DS_BIT];
    assign w_from_ds = i_frame_control[FC_FROM_DS_BIT];

    always_comb begin
        w_prefix     = i_addr_at_10_prefix;
        w_has_source = 1'b0;
        case (w_type)
            FT_MGMT: begin
                w_has_source = i_frame_length >= LEN_W'(HEADER_BYTES);
            end
            FT_CTRL: begin
                // Only the control subtypes that carry a transmitter address.
                w_has_source = (w_subtype inside {[CTRL_SUB_LO:CTRL_SUB_HI]})
                               && (i_frame_length >= LEN_W'(CTRL_MIN_BYTES));
            end
            FT_DATA: begin
                if (w_to_ds && w_from_ds) begin
                    w_prefix     = i_addr_at_24_prefix;
                    w_has_source = i_frame_length >= LEN_W'(HEADER_BYTES + ADDR4_BYTES);
                end else begin
                    if (w_from_ds) begin
                        w_prefix = i_addr_at_16_prefix;
                    end
                    w_has_source = i_frame_length >= LEN_W'(HEADER_BYTES);
                end
            end
            default: begin
                w_has_source = 1'b0;
            end
        endcase
    end

    assign o_match.has_source = w_has_source;
    assign o_match.listed     = prefix_listed(w_prefix);

endmodule

`default_nettype wire

// ===== src/wcfrh_usec_split.sv =====
// ----------------------------------------------------------------------------
// wcfrh_usec_split
// Two pipeline stages that split a microsecond timestamp into seconds and
// microseconds; the second stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wcfrh_usec_split (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [wcfrh_pkg::TS_W-1:0]   i_ts,
    input  wire wcfrh_pkg::t_outcome          i_outcome,
    input  wire logic [wcfrh_pkg::LEN_W-1:0]  i_len,
    wcfrh_rec_if.source                       o_rec
);
    import wcfrh_pkg::*;

    // Stage 2: reciprocal multiply.
    logic              r_s2_valid;
    logic [SEC_W-1:0]  r_s2_q;
    logic [TS_W-1:0]   r_s2_ts;
    t_outcome          r_s2_outcome;
    logic [LEN_W-1:0]  r_s2_len;

    // Stage 3: remainder, correction and output register.
    logic              r_s3_valid;
    logic [SEC_W-1:0]  r_s3_sec;
    logic [USEC_W-1:0] r_s3_usec;
    t_outcome          r_s3_outcome;
    logic [LEN_W-1:0]  r_s3_len;

    logic              w_s2_ready;
    logic              w_s3_ready;
    logic [PROD_W-1:0] w_prod;
    logic [TS_W-1:0]   w_qm;
    logic [TS_W-1:0]   w_rem;
    logic              w_fix;
    logic [SEC_W-1:0]  n_sec;
    logic [USEC_W-1:0] n_usec;

    assign w_s3_ready = !r_s3_valid || o_rec.ready;
    assign w_s2_ready = !r_s2_valid || w_s3_ready;
    assign o_ready    = w_s2_ready;

    assign w_prod = PROD_W'(i_ts) * PROD_W'(RECIP_MULT);

    // The estimated quotient is exact or one short.
    assign w_qm   = TS_W'(r_s2_q) * TS_W'(USEC_PER_SEC);
    assign w_rem  = r_s2_ts - w_qm;
    assign w_fix  = w_rem >= TS_W'(USEC_PER_SEC);
    assign n_sec  = w_fix ? (r_s2_q + SEC_W'(1)) : r_s2_q;
    assign n_usec = w_fix ? USEC_W'(w_rem - TS_W'(USEC_PER_SEC)) : USEC_W'(w_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= i_valid;
        end
        if (w_s2_ready && i_valid) begin
            r_s2_q       <= w_prod[RECIP_SHIFT +: SEC_W];
            r_s2_ts      <= i_ts;
            r_s2_outcome <= i_outcome;
            r_s2_len     <= i_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
        if (w_s3_ready && r_s2_valid) begin
            r_s3_sec     <= n_sec;
            r_s3_usec    <= n_usec;
            r_s3_outcome <= r_s2_outcome;
            r_s3_len     <= r_s2_len;
        end
    end

    assign o_rec.valid           = r_s3_valid;
    assign o_rec.outcome         = r_s3_outcome;
    assign o_rec.seconds         = r_s3_sec;
    assign o_rec.microseconds    = r_s3_usec;
    assign o_rec.captured_length = r_s3_len;

endmodule

`default_nettype wire
